// ===== rtl/core/dtrp_pkg.sv =====
`default_nettype none
// ============================================================================
// dtrp_pkg
// Shared types, constants and helpers of the depth table row parser.
// ============================================================================
package dtrp_pkg;

   // Fixed field widths of the stream payloads.
   localparam int COL_W       = 10;
   localparam int DEPTH_W     = 16;
   localparam int GROUP_W     = 2;
   localparam int COUNT_W     = 11;
   localparam int FIELD_W     = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int IN_TDATA_W  = 24;
   localparam int OUT_TDATA_W = 56;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_FLOOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_ENABLE = 2'd1;

   // Input transaction function codes.
   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_TABLE = 1'b1;

   // Result kinds.
   localparam logic KIND_DEPTH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Characters of the table format.
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   // A closed field (or row end) handed from the scanner to the tally stage.
   typedef struct packed {
      logic               row_end;
      logic               has_depth;
      logic [COL_W-1:0]   column;
      logic [DEPTH_W-1:0] depth;
      logic               passes;
      logic               clipped;
      logic               counted;
   } close_event_type;

   // Saturating increment used by the field index and all the counters.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v < COUNT_MAX) ? v + 11'd1 : v;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dtrp_colmem.sv =====
`default_nettype none
// ============================================================================
// dtrp_colmem
// Column-to-group memory with a registered read and a clearing sweep after reset.
// ============================================================================
module dtrp_colmem #(
   parameter int MAX_COLUMNS = 1024,
   parameter int AW          = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic [dtrp_pkg::GROUP_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   output logic      [dtrp_pkg::GROUP_W-1:0] rd_data,
   output logic                              busy
);
   import dtrp_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLUMNS - 1);

   logic [GROUP_W-1:0] mem [MAX_COLUMNS];
   logic [GROUP_W-1:0] rd_data_ff;
   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               mw_en;
   logic [AW-1:0]      mw_addr;
   logic [GROUP_W-1:0] mw_data;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
      // The sweep owns the write port while it runs.
      mw_en   = clr_busy_ff || wr_en;
      mw_addr = clr_busy_ff ? clr_addr_ff : wr_addr;
      mw_data = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         mem[mw_addr] <= mw_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

// ===== rtl/core/dtrp_scan.sv =====
`default_nettype none
// ============================================================================
// dtrp_scan
// Byte scanner: splits fields, accumulates decimal depths, raises close events.
// ============================================================================
module dtrp_scan #(
   parameter int MAX_COLUMNS = 1024,
   parameter int GROUP_COUNT = 4,
   parameter int DEPTH_BITS  = 16,
   parameter int AW          = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic                         func,
   input  wire logic [7:0]                   byte_in,
   input  wire logic [dtrp_pkg::COL_W-1:0]   column_sel,
   input  wire logic [dtrp_pkg::GROUP_W-1:0] group_sel,
   input  wire logic [dtrp_pkg::DEPTH_W-1:0] depth_floor,
   output logic                              ev_valid,
   output dtrp_pkg::close_event_type         ev,
   output logic      [AW-1:0]                rd_addr,
   output logic                              wr_en,
   output logic      [AW-1:0]                wr_addr,
   output logic      [dtrp_pkg::GROUP_W-1:0] wr_data
);
   import dtrp_pkg::*;

   localparam int MW = DEPTH_BITS + 4;
   localparam logic [MW-1:0] DEPTH_MAX = MW'((64'd1 << DEPTH_BITS) - 64'd1);

   logic [FIELD_W-1:0]    field_ff, field_in;
   logic [DEPTH_BITS-1:0] accum_ff, accum_in;
   logic                  ovf_ff, ovf_in;

   logic                  data_fire, is_tab, is_nl, is_digit, close;
   logic [7:0]            digit_full;
   logic [MW-1:0]         product;
   logic [FIELD_W-1:0]    col;
   logic [31:0]           col32, sel32, accum32;
   logic                  has_depth, beyond, pass;

   always_comb begin
      data_fire  = fire && (func == FUNC_DATA);
      is_tab     = byte_in == CHAR_TAB;
      is_nl      = byte_in == CHAR_NEWLINE;
      is_digit   = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
      close      = data_fire && (is_tab || is_nl);
      digit_full = byte_in - CHAR_ZERO;
      // depth*10 + digit as two shifted copies plus the digit.
      product    = (MW'(accum_ff) << 3) + (MW'(accum_ff) << 1) + MW'(digit_full[3:0]);

      col       = field_ff - FIELD_W'(2);
      col32     = 32'(col);
      accum32   = 32'(accum_ff);
      has_depth = field_ff >= FIELD_W'(2);
      beyond    = col32 >= 32'(MAX_COLUMNS);
      pass      = accum32 >= 32'(depth_floor);

      ev.row_end   = is_nl;
      ev.has_depth = has_depth;
      ev.column    = col[COL_W-1:0];
      ev.depth     = accum32[DEPTH_W-1:0];
      ev.passes    = pass;
      ev.clipped   = ovf_ff || beyond;
      ev.counted   = pass && !beyond;
      // Tabs closing the identifier and sequence fields produce nothing.
      ev_valid     = close && (is_nl || has_depth);
      rd_addr      = col32[AW-1:0];

      sel32   = 32'(column_sel);
      wr_en   = fire && (func == FUNC_TABLE) && (sel32 < 32'(MAX_COLUMNS))
                && (32'(group_sel) < 32'(GROUP_COUNT));
      wr_addr = sel32[AW-1:0];
      wr_data = group_sel;

      field_in = field_ff;
      accum_in = accum_ff;
      ovf_in   = ovf_ff;
      if (close) begin
         accum_in = '0;
         ovf_in   = 1'b0;
         field_in = is_nl ? '0 : sat_inc(field_ff);
      end else if (data_fire && is_digit) begin
         if (product > DEPTH_MAX) begin
            accum_in = DEPTH_MAX[DEPTH_BITS-1:0];
            ovf_in   = 1'b1;
         end else begin
            accum_in = product[DEPTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= '0;
         accum_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         field_ff <= field_in;
         accum_ff <= accum_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dtrp_tally.sv =====
`default_nettype none
// ============================================================================
// dtrp_tally
// Counts passing columns, sequences depth and summary results, output register.
// ============================================================================
module dtrp_tally #(
   parameter int GROUP_COUNT = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             ev_valid,
   input  wire dtrp_pkg::close_event_type        ev,
   input  wire logic [dtrp_pkg::GROUP_W-1:0]     grp,
   input  wire logic                             group_enable,
   output logic                                  ev_ready,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [dtrp_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import dtrp_pkg::*;

   localparam int SW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam logic [SW-1:0] SUM_LAST = SW'(GROUP_COUNT - 1);

   // Event stage.
   logic               b_valid_ff, b_valid_in;
   logic               pend_ff, pend_in;
   close_event_type    b_ev_ff, b_ev_in;
   logic [SW-1:0]      sum_idx_ff, sum_idx_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] cnt_ff [GROUP_COUNT];
   logic [COUNT_W-1:0] cnt_in [GROUP_COUNT];

   // Output register.
   logic               o_valid_ff, o_valid_in;
   logic               o_kind_ff, o_kind_in;
   logic [COL_W-1:0]   o_col_ff, o_col_in;
   logic [DEPTH_W-1:0] o_depth_ff, o_depth_in;
   logic               o_pass_ff, o_pass_in;
   logic               o_clip_ff, o_clip_in;
   logic [GROUP_W-1:0] o_grp_ff, o_grp_in;
   logic [COUNT_W-1:0] o_gcnt_ff, o_gcnt_in;
   logic [COUNT_W-1:0] o_tcnt_ff, o_tcnt_in;
   logic               o_last_ff, o_last_in;

   logic               out_free, step, emit_depth, emit_sum, sum_last, finish;
   logic               grp_inc;
   logic [31:0]        sum32;

   always_comb begin
      out_free   = !o_valid_ff || rsp_tready;
      step       = b_valid_ff && out_free;
      emit_depth = step && pend_ff;
      emit_sum   = step && !pend_ff;
      sum_last   = sum_idx_ff == SUM_LAST;
      finish     = (emit_depth && !b_ev_ff.row_end) || (emit_sum && sum_last);
      ev_ready   = !b_valid_ff || finish;
      grp_inc    = b_ev_ff.counted && group_enable && (32'(grp) < 32'(GROUP_COUNT));
      sum32      = 32'(sum_idx_ff);

      b_valid_in = b_valid_ff;
      pend_in    = pend_ff;
      b_ev_in    = b_ev_ff;
      sum_idx_in = sum_idx_ff;
      total_in   = total_ff;
      cnt_in     = cnt_ff;

      o_valid_in = o_valid_ff && !rsp_tready;
      o_kind_in  = o_kind_ff;
      o_col_in   = o_col_ff;
      o_depth_in = o_depth_ff;
      o_pass_in  = o_pass_ff;
      o_clip_in  = o_clip_ff;
      o_grp_in   = o_grp_ff;
      o_gcnt_in  = o_gcnt_ff;
      o_tcnt_in  = o_tcnt_ff;
      o_last_in  = o_last_ff;

      if (emit_depth) begin
         o_valid_in = 1'b1;
         o_kind_in  = KIND_DEPTH;
         o_col_in   = b_ev_ff.column;
         o_depth_in = b_ev_ff.depth;
         o_pass_in  = b_ev_ff.passes;
         o_clip_in  = b_ev_ff.clipped;
         o_grp_in   = '0;
         o_gcnt_in  = '0;
         o_tcnt_in  = '0;
         o_last_in  = !b_ev_ff.row_end;
         pend_in    = 1'b0;
         if (b_ev_ff.counted) begin
            total_in = sat_inc(total_ff);
         end
         for (int i = 0; i < GROUP_COUNT; i++) begin
            if (grp_inc && (32'(i) == 32'(grp))) begin
               cnt_in[i] = sat_inc(cnt_ff[i]);
            end
         end
      end else if (emit_sum) begin
         o_valid_in = 1'b1;
         o_kind_in  = KIND_SUMMARY;
         o_col_in   = '0;
         o_depth_in = '0;
         o_pass_in  = 1'b0;
         o_clip_in  = 1'b0;
         o_grp_in   = sum32[GROUP_W-1:0];
         o_gcnt_in  = cnt_ff[0];
         o_tcnt_in  = total_ff;
         o_last_in  = sum_last;
         // Counters shift down one place per summary and are empty afterwards.
         for (int i = 0; i < GROUP_COUNT; i++) begin
            cnt_in[i] = (i == GROUP_COUNT - 1) ? '0 : cnt_ff[(i + 1) % GROUP_COUNT];
         end
         if (sum_last) begin
            sum_idx_in = '0;
            total_in   = '0;
         end else begin
            sum_idx_in = sum_idx_ff + SW'(1);
         end
      end

      if (finish) begin
         b_valid_in = 1'b0;
      end
      if (ev_valid) begin
         b_valid_in = 1'b1;
         pend_in    = ev.has_depth;
         b_ev_in    = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         pend_ff    <= 1'b0;
         sum_idx_ff <= '0;
         total_ff   <= '0;
         o_valid_ff <= 1'b0;
         for (int i = 0; i < GROUP_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         b_valid_ff <= b_valid_in;
         pend_ff    <= pend_in;
         sum_idx_ff <= sum_idx_in;
         total_ff   <= total_in;
         o_valid_ff <= o_valid_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ev_ff    <= b_ev_in;
      o_kind_ff  <= o_kind_in;
      o_col_ff   <= o_col_in;
      o_depth_ff <= o_depth_in;
      o_pass_ff  <= o_pass_in;
      o_clip_ff  <= o_clip_in;
      o_grp_ff   <= o_grp_in;
      o_gcnt_ff  <= o_gcnt_in;
      o_tcnt_ff  <= o_tcnt_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {4'd0, o_tcnt_ff, o_gcnt_ff, o_grp_ff, o_clip_ff, o_pass_ff,
                        o_depth_ff, o_col_ff};

endmodule
`default_nettype wire

// ===== rtl/core/depth_table_row_parser.sv =====
`default_nettype none
// A depth result passes the event stage and then the output register after its tab or newline.
// Throughput: one byte or table write per cycle while the output does not stall; a newline holds
// the input until its summaries, one per group, have left one a cycle as the output takes them.
// Reset: synchronous; afterwards the column group memory is swept to group zero, one entry
// per cycle over all MAX_COLUMNS entries, during which req_tready stays low.
// ============================================================================
// depth_table_row_parser
// Streaming parser of a tab-separated depth table with per-row group summaries.
// ============================================================================
module depth_table_row_parser #(
   parameter int MAX_COLUMNS = 1024,
   parameter int GROUP_COUNT = 4,
   parameter int DEPTH_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input stream.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // byte_in [7:0], column_sel [17:8], group_sel [19:18], zeros [23:20]
   input  wire logic [dtrp_pkg::IN_TDATA_W-1:0]    req_tdata,
   // func [0]
   input  wire logic                               req_tuser,
   // Result stream.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // column [9:0], depth [25:10], passes [26], clipped [27], group [29:28],
   // group_count [40:30], total_count [51:41], zeros [55:52]
   output logic      [dtrp_pkg::OUT_TDATA_W-1:0]   rsp_tdata,
   // kind [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   // Configuration write channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dtrp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dtrp_pkg::DEPTH_W-1:0]       csr_data
);
   import dtrp_pkg::*;

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   // Configuration registers. Writes are taken at any time; the user only
   // changes them while no transaction is in flight.
   logic [DEPTH_W-1:0] depth_floor_ff, depth_floor_in;
   logic               group_enable_ff, group_enable_in;

   logic               fire;
   logic               clear_busy;
   logic               ev_valid, ev_ready;
   close_event_type    ev;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   logic [GROUP_W-1:0] wr_data, grp;

   assign csr_ready = 1'b1;

   always_comb begin
      depth_floor_in  = depth_floor_ff;
      group_enable_in = group_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEPTH_FLOOR:  depth_floor_in  = csr_data;
            CSR_GROUP_ENABLE: group_enable_in = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_floor_ff  <= 16'd1;
         group_enable_ff <= 1'b1;
      end else begin
         depth_floor_ff  <= depth_floor_in;
         group_enable_ff <= group_enable_in;
      end
   end

   // The input waits for the clearing sweep and for room in the event stage.
   // Table writes obey the same rule, which keeps the ready free of payload.
   assign req_tready = !clear_busy && ev_ready;
   assign fire       = req_tvalid && req_tready;

   // The scanner closes a field in the accept cycle and issues the memory read
   // for its column at the same edge, so the group arrives together with the
   // event in the tally stage. A table write and a close are never the same
   // transaction, and a read after a write to the same entry sees the new
   // value, so the order of the transactions is kept without forwarding.
   dtrp_scan #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .GROUP_COUNT(GROUP_COUNT),
      .DEPTH_BITS (DEPTH_BITS),
      .AW         (AW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .func       (req_tuser),
      .byte_in    (req_tdata[7:0]),
      .column_sel (req_tdata[17:8]),
      .group_sel  (req_tdata[19:18]),
      .depth_floor(depth_floor_ff),
      .ev_valid   (ev_valid),
      .ev         (ev),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   dtrp_colmem #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .AW         (AW)
   ) u_colmem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ev_valid),
      .rd_addr(rd_addr),
      .rd_data(grp),
      .busy   (clear_busy)
   );

   // The tally stage counts the column when its depth result enters the
   // output register, then at a row end streams the group summaries.
   dtrp_tally #(
      .GROUP_COUNT(GROUP_COUNT)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (ev_valid),
      .ev          (ev),
      .grp         (grp),
      .group_enable(group_enable_ff),
      .ev_ready    (ev_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== rtl/core/dtrp_check.sv =====
`default_nettype none
// ============================================================================
// dtrp_check
// Port-level checks of the depth table row parser, bound to the top level.
// ============================================================================
module dtrp_check #(
   parameter int GROUP_COUNT = 4
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [dtrp_pkg::OUT_TDATA_W-1:0]   rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast
);
   import dtrp_pkg::*;

   localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(GROUP_COUNT - 1);

   // After reset nothing is shown and the clearing sweep holds the input.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("result or input ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY) |-> rsp_tdata[27:0] == 28'd0)
      else $error("summary carries depth fields");

   a_depth_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DEPTH) |-> rsp_tdata[55:28] == 28'd0)
      else $error("depth result carries summary fields");

   a_last_group: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY) && rsp_tlast
         |-> rsp_tdata[29:28] == LAST_GROUP)
      else $error("row closed on a summary other than the last group");

endmodule

bind depth_table_row_parser dtrp_check #(
   .GROUP_COUNT(GROUP_COUNT)
) u_dtrp_check (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
`default_nettype wire
